>>> hdl/ysd_pkg.sv
// ysd_pkg: shared types, constants and the opcode classifier for the y86 decoder
// used by ysd_front, ysd_queue, ysd_back and y86_instruction_stream_decoder
`default_nettype none

package ysd_pkg;

   // program memory size and address width
   localparam int MEM_BYTES   = 4096;
   localparam int ADDR_W      = $clog2(MEM_BYTES);
   localparam int START_W     = 12;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // opcode upper nibbles
   localparam logic [3:0] OPH_HALT   = 4'h0;
   localparam logic [3:0] OPH_NOP    = 4'h1;
   localparam logic [3:0] OPH_RRMOV  = 4'h2;
   localparam logic [3:0] OPH_IRMOV  = 4'h3;
   localparam logic [3:0] OPH_RMMOV  = 4'h4;
   localparam logic [3:0] OPH_MRMOV  = 4'h5;
   localparam logic [3:0] OPH_ALU    = 4'h6;
   localparam logic [3:0] OPH_JUMP   = 4'h7;
   localparam logic [3:0] OPH_CALL   = 4'h8;
   localparam logic [3:0] OPH_RET    = 4'h9;
   localparam logic [3:0] OPH_PUSH   = 4'hA;
   localparam logic [3:0] OPH_POP    = 4'hB;

   // largest function code for the families that have one
   localparam logic [3:0] FN_CMOV_MAX = 4'h6;
   localparam logic [3:0] FN_ALU_MAX  = 4'h3;
   localparam logic [3:0] FN_JUMP_MAX = 4'h6;
   localparam logic [3:0] FN_NONE     = 4'h0;

   // mnemonic codes (family bases)
   localparam logic [4:0] MN_HALT   = 5'd0;
   localparam logic [4:0] MN_NOP    = 5'd1;
   localparam logic [4:0] MN_RET    = 5'd2;
   localparam logic [4:0] MN_RRMOVL = 5'd3;
   localparam logic [4:0] MN_ADDL   = 5'd10;
   localparam logic [4:0] MN_PUSHL  = 5'd14;
   localparam logic [4:0] MN_POPL   = 5'd15;
   localparam logic [4:0] MN_IRMOVL = 5'd16;
   localparam logic [4:0] MN_RMMOVL = 5'd17;
   localparam logic [4:0] MN_MRMOVL = 5'd18;
   localparam logic [4:0] MN_JMP    = 5'd19;
   localparam logic [4:0] MN_CALL   = 5'd26;

   // instruction lengths, zero marks an unknown opcode
   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_SHORT = 3'd1;
   localparam logic [2:0] LEN_REG   = 3'd2;
   localparam logic [2:0] LEN_JUMP  = 3'd5;
   localparam logic [2:0] LEN_LONG  = 3'd6;

   typedef struct packed {
      logic [2:0] len;
      logic [4:0] code;
   } class_type;

   // one queued word: the byte, its address and its class as an opcode
   typedef struct packed {
      logic [7:0]        code_byte;
      logic              final_byte;
      logic [ADDR_W-1:0] addr;
      class_type         cls;
   } entry_type;

   function automatic class_type classify(input logic [7:0] op);
      logic [3:0] hi;
      logic [3:0] lo;
      class_type  c;
      hi = op[7:4];
      lo = op[3:0];
      c.len  = LEN_NONE;
      c.code = MN_HALT;
      case (hi)
         OPH_HALT:  if (lo == FN_NONE) begin c.len = LEN_SHORT; c.code = MN_HALT; end
         OPH_NOP:   if (lo == FN_NONE) begin c.len = LEN_SHORT; c.code = MN_NOP; end
         OPH_RET:   if (lo == FN_NONE) begin c.len = LEN_SHORT; c.code = MN_RET; end
         OPH_RRMOV: if (lo <= FN_CMOV_MAX) begin
            c.len = LEN_REG; c.code = MN_RRMOVL + {1'b0, lo};
         end
         OPH_ALU:   if (lo <= FN_ALU_MAX) begin
            c.len = LEN_REG; c.code = MN_ADDL + {1'b0, lo};
         end
         OPH_PUSH:  if (lo == FN_NONE) begin c.len = LEN_REG; c.code = MN_PUSHL; end
         OPH_POP:   if (lo == FN_NONE) begin c.len = LEN_REG; c.code = MN_POPL; end
         OPH_IRMOV: if (lo == FN_NONE) begin c.len = LEN_LONG; c.code = MN_IRMOVL; end
         OPH_RMMOV: if (lo == FN_NONE) begin c.len = LEN_LONG; c.code = MN_RMMOVL; end
         OPH_MRMOV: if (lo == FN_NONE) begin c.len = LEN_LONG; c.code = MN_MRMOVL; end
         OPH_JUMP:  if (lo <= FN_JUMP_MAX) begin
            c.len = LEN_JUMP; c.code = MN_JMP + {1'b0, lo};
         end
         OPH_CALL:  if (lo == FN_NONE) begin c.len = LEN_JUMP; c.code = MN_CALL; end
         default: begin
            c.len  = LEN_NONE;
            c.code = MN_HALT;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hdl/ysd_front.sv
// ysd_front: accepts program bytes, tracks the byte address and classifies each byte
// depends on ysd_pkg
`default_nettype none

module ysd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_code_byte,
   input  wire logic             req_final_byte,
   input  wire logic             queue_full,
   output logic                  push,
   output ysd_pkg::entry_type    push_entry
);
   import ysd_pkg::*;

   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;

   // accept whenever the queue has room
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // classify the byte as if it were an opcode; the back decides if it is one
   always_comb begin
      push_entry.code_byte  = req_code_byte;
      push_entry.final_byte = req_final_byte;
      push_entry.addr       = addr_ff;
      push_entry.cls        = classify(req_code_byte);
   end

   // address advances per byte, wraps at memory size, restarts after the final byte
   always_comb begin
      addr_in = addr_ff;
      if (push) begin
         if (req_final_byte || addr_ff == ADDR_W'(MEM_BYTES - 1)) begin
            addr_in = '0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ysd_queue.sv
// ysd_queue: short fifo of classified words between front and back
// depends on ysd_pkg
`default_nettype none

module ysd_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire ysd_pkg::entry_type push_entry,
   input  wire logic            pop,
   output logic                 full,
   output logic                 head_valid,
   output ysd_pkg::entry_type   head_entry
);
   import ysd_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ysd_back.sv
// ysd_back: assembles instruction bytes from the queue and holds the result word
// depends on ysd_pkg
`default_nettype none

module ysd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire ysd_pkg::entry_type  head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [4:0]               rsp_mnemonic,
   output logic [3:0]               rsp_reg_a,
   output logic [3:0]               rsp_reg_b,
   output logic signed [31:0]       rsp_immediate,
   output logic [ysd_pkg::START_W-1:0] rsp_start_address,
   output logic [2:0]               rsp_length,
   output logic                     rsp_truncated
);
   import ysd_pkg::*;

   // instruction being collected
   logic [2:0]        count_ff;
   logic [2:0]        count_in;
   logic [2:0]        len_ff;
   logic [2:0]        len_in;
   logic [4:0]        code_ff;
   logic [4:0]        code_in;
   logic [7:0]        regs_ff;
   logic [7:0]        regs_in;
   logic [31:0]       imm_ff;
   logic [31:0]       imm_in;
   logic [ADDR_W-1:0] start_ff;
   logic [ADDR_W-1:0] start_in;

   // result register
   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic [4:0]               out_code_ff;
   logic [3:0]               out_reg_a_ff;
   logic [3:0]               out_reg_b_ff;
   logic [31:0]              out_imm_ff;
   logic [START_W-1:0]       out_start_ff;
   logic [2:0]               out_len_ff;
   logic                     out_trunc_ff;

   logic       emit;
   logic       trunc;
   logic       has_reg;
   logic       has_imm;
   logic [2:0] next_count;
   logic [1:0] lane;
   logic       lane_hit;

   // take a word when the result register is free or being emptied
   assign pop = head_valid && (!out_valid_ff || rsp_ready);

   // byte assembly
   always_comb begin
      count_in   = count_ff;
      len_in     = len_ff;
      code_in    = code_ff;
      regs_in    = regs_ff;
      imm_in     = imm_ff;
      start_in   = start_ff;
      emit       = 1'b0;
      trunc      = 1'b0;
      next_count = count_ff + 1'b1;
      lane       = '0;
      lane_hit   = 1'b0;
      if (pop) begin
         if (count_ff == '0) begin
            // waiting for an opcode: unknown bytes are skipped
            if (head_entry.cls.len != LEN_NONE) begin
               len_in   = head_entry.cls.len;
               code_in  = head_entry.cls.code;
               regs_in  = '0;
               imm_in   = '0;
               start_in = head_entry.addr;
               if (head_entry.cls.len == LEN_SHORT) begin
                  emit = 1'b1;
               end else if (head_entry.final_byte) begin
                  emit  = 1'b1;
                  trunc = 1'b1;
               end else begin
                  count_in = 3'd1;
               end
            end
         end else begin
            // jumps carry the immediate from byte one, long forms from byte two
            if (len_ff == LEN_JUMP) begin
               lane     = 2'(count_ff - 3'd1);
               lane_hit = 1'b1;
            end else if (count_ff == 3'd1) begin
               regs_in = head_entry.code_byte;
            end else begin
               lane     = 2'(count_ff - 3'd2);
               lane_hit = 1'b1;
            end
            if (lane_hit) begin
               case (lane)
                  2'd0:    imm_in[7:0]   = head_entry.code_byte;
                  2'd1:    imm_in[15:8]  = head_entry.code_byte;
                  2'd2:    imm_in[23:16] = head_entry.code_byte;
                  2'd3:    imm_in[31:24] = head_entry.code_byte;
                  default: imm_in        = imm_ff;
               endcase
            end
            if (next_count >= len_ff) begin
               emit     = 1'b1;
               count_in = '0;
            end else if (head_entry.final_byte) begin
               emit     = 1'b1;
               trunc    = 1'b1;
               count_in = '0;
            end else begin
               count_in = next_count;
            end
         end
      end
   end

   assign has_reg = (len_in == LEN_REG) || (len_in == LEN_LONG);
   assign has_imm = (len_in == LEN_JUMP) || (len_in == LEN_LONG);

   // result handshake
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // held instruction fields
   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      code_ff  <= code_in;
      regs_ff  <= regs_in;
      imm_ff   <= imm_in;
      start_ff <= start_in;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         out_code_ff  <= code_in;
         out_reg_a_ff <= has_reg ? regs_in[7:4] : 4'd0;
         out_reg_b_ff <= has_reg ? regs_in[3:0] : 4'd0;
         out_imm_ff   <= has_imm ? imm_in : 32'd0;
         out_start_ff <= START_W'(start_in);
         out_len_ff   <= len_in;
         out_trunc_ff <= trunc;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_mnemonic      = out_code_ff;
   assign rsp_reg_a         = out_reg_a_ff;
   assign rsp_reg_b         = out_reg_b_ff;
   assign rsp_immediate     = $signed(out_imm_ff);
   assign rsp_start_address = out_start_ff;
   assign rsp_length        = out_len_ff;
   assign rsp_truncated     = out_trunc_ff;

endmodule

`default_nettype wire

>>> hdl/y86_instruction_stream_decoder.sv
// y86_instruction_stream_decoder: top level, byte stream in, decoded instruction words out
// depends on ysd_pkg, ysd_front, ysd_queue, ysd_back
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------------
//   req     | req_valid / req_ready | code_byte, final_byte
//   rsp     | rsp_valid / rsp_ready | mnemonic, reg_a, reg_b, immediate, start_address,
//           |                       | length, truncated
//
// one byte word accepted per cycle while the queue is not full; a result word passes
// through the front-to-back queue and then the result register
// the two-entry queue keeps byte intake going while the result register waits on rsp_ready
// reset is synchronous: byte address zero, decoder waiting for an opcode, queue empty
`default_nettype none

module y86_instruction_stream_decoder (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_code_byte,
   input  wire logic                   req_final_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [4:0]                  rsp_mnemonic,
   output logic [3:0]                  rsp_reg_a,
   output logic [3:0]                  rsp_reg_b,
   output logic signed [31:0]          rsp_immediate,
   output logic [ysd_pkg::START_W-1:0] rsp_start_address,
   output logic [2:0]                  rsp_length,
   output logic                        rsp_truncated
);
   import ysd_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   // intake and classification
   ysd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_byte  (req_code_byte),
      .req_final_byte (req_final_byte),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   // decoupling queue
   ysd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // instruction assembly and result register
   ysd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mnemonic      (rsp_mnemonic),
      .rsp_reg_a         (rsp_reg_a),
      .rsp_reg_b         (rsp_reg_b),
      .rsp_immediate     (rsp_immediate),
      .rsp_start_address (rsp_start_address),
      .rsp_length        (rsp_length),
      .rsp_truncated     (rsp_truncated)
   );

`ifndef NO_ASSERTIONS
   // a result word always carries a legal instruction length
   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length == LEN_SHORT || rsp_length == LEN_REG ||
                     rsp_length == LEN_JUMP || rsp_length == LEN_LONG))
      else $error("result word with illegal length");

   // one-byte instructions can never be cut short
   a_short_not_trunc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_length == LEN_SHORT) |-> !rsp_truncated)
      else $error("one-byte instruction flagged truncated");

   // one-byte instructions have no register byte and no immediate
   a_short_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_length == LEN_SHORT) |->
         (rsp_reg_a == 4'd0 && rsp_reg_b == 4'd0 && rsp_immediate == 32'sd0))
      else $error("one-byte instruction carries operands");

   // the back never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
